### rtl/particle_pool_step_macros.svh
// ----------------------------------------------------------------------------
// particle pool assertion macros
// shared concurrent assertion forms for the particle pool rtl
// ----------------------------------------------------------------------------
`ifndef PARTICLE_POOL_STEP_MACROS_SVH
`define PARTICLE_POOL_STEP_MACROS_SVH

// checked only outside reset
`define PPS_ASSERT_RUN(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked at every edge, reset included
`define PPS_ASSERT_ALL(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/pps_pkg.sv
// ----------------------------------------------------------------------------
// pps_pkg
// constants, slot record and sequencer states of the particle pool
// ----------------------------------------------------------------------------
`default_nettype none

package pps_pkg;

  localparam int SLOTS  = 64;
  localparam int SLOT_W = $clog2(SLOTS);
  localparam int CNT_W  = $clog2(SLOTS + 1);

  typedef enum logic [1:0] {
    CMD_EMIT = 2'd0,
    CMD_ADV  = 2'd1,
    CMD_READ = 2'd2,
    CMD_NOP  = 2'd3
  } cmd_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
    logic [31:0]        color;
    logic [15:0]        psize;
    logic signed [24:0] life;
    logic [23:0]        full;
  } slot_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EM_SCAN,
    S_AD_SCAN,
    S_AD_RD,
    S_AD_MUL,
    S_AD_ADD,
    S_AD_LIFE,
    S_AD_DIV,
    S_AD_WR,
    S_RO_SCAN,
    S_RO_CAP,
    S_RO_END
  } state_t;

endpackage

`default_nettype wire

### rtl/pps_div.sv
// ----------------------------------------------------------------------------
// pps_div
// restoring divider for the alpha byte, one quotient bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module pps_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] num,
  input  logic [23:0] den,
  output logic        done,
  output logic [7:0]  quo
);

  logic        run;
  logic [2:0]  cnt;
  logic [31:0] rem;
  logic [31:0] dsh;
  logic [32:0] trial;

  assign trial = {1'b0, rem} - {1'b0, dsh};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        if (num >= {den, 8'b0}) begin
          quo  <= 8'hff;
          done <= 1'b1;
        end else begin
          run <= 1'b1;
          rem <= num;
          dsh <= {1'b0, den, 7'b0};
          cnt <= 3'd7;
          quo <= '0;
        end
      end else if (run) begin
        if (!trial[32]) begin
          rem <= trial[31:0];
        end
        quo <= {quo[6:0], ~trial[32]};
        dsh <= {1'b0, dsh[31:1]};
        cnt <= cnt - 3'd1;
        if (cnt == 3'd0) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

### rtl/particle_pool_step.sv
// ----------------------------------------------------------------------------
// particle_pool_step
// fixed pool of particle slots with an euler time step
// ----------------------------------------------------------------------------
// an item is taken when start is high and busy is low. cmd emit writes the
// item into the lowest dead slot (dropped when none is free), cmd advance
// moves every live slot by velocity*dt, ages it and fades its alpha, then
// recounts, cmd read gives every live slot in slot order with last on the
// final one. results appear on out_strobe for one cycle each; the receiver
// cannot stall them.
// steps: emit scans up from slot 0 for the first dead slot. advance skips dead
// slots; for a live one it reads the slot, runs each axis in turn through the
// shared multiplier and the adder, ages it, runs the 8-step alpha divider
// unless the alpha fades to zero, then writes the slot back. read results
// trail their slot by one live slot; the final result follows the scan end.
// busy is high until the item ends; it falls as the final result strobes.
// reset kills every slot and clears the live tally; slot storage itself is
// not cleared, live flags mask it. cmd 3 is taken and does nothing.
// ----------------------------------------------------------------------------
`default_nettype none

`include "particle_pool_step_macros.svh"

module particle_pool_step (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          cmd,
  input  logic signed [31:0]  pos_x,
  input  logic signed [31:0]  pos_y,
  input  logic signed [31:0]  pos_z,
  input  logic signed [31:0]  vel_x,
  input  logic signed [31:0]  vel_y,
  input  logic signed [31:0]  vel_z,
  input  logic [31:0]         color_rgba,
  input  logic [15:0]         point_size,
  input  logic [23:0]         lifetime,
  input  logic [23:0]         dt,
  output logic                out_strobe,
  output logic signed [31:0]  out_pos_x,
  output logic signed [31:0]  out_pos_y,
  output logic signed [31:0]  out_pos_z,
  output logic [31:0]         out_color_rgba,
  output logic [15:0]         out_point_size,
  output logic [6:0]          live_count,
  output logic                last
);

  import pps_pkg::*;

  state_t             state, state_next;
  slot_t              mem [SLOTS];
  slot_t              rec_q, wrk, in_rec, pend, mem_wdata;
  logic               mem_we;
  logic [SLOTS-1:0]   live;
  logic [SLOT_W-1:0]  idx;
  logic               idx_last;
  logic [CNT_W-1:0]   cnt, tally;
  logic [23:0]        dt_q;
  logic [1:0]         ax;
  logic signed [56:0] prod;
  logic signed [31:0] vel_sel, pos_sel, pos_new;
  logic signed [41:0] sum;
  logic signed [24:0] life_new;
  logic               life_new_pos, wrk_live;
  logic [31:0]        div_num;
  logic               div_start, div_done;
  logic [7:0]         div_quo;
  logic               pend_v;
  logic               accept;

  assign accept   = start && !busy;
  assign idx_last = (idx == SLOT_W'(SLOTS - 1));

  always_comb begin
    unique case (ax)
      2'd0:    begin vel_sel = wrk.vel_x; pos_sel = wrk.pos_x; end
      2'd1:    begin vel_sel = wrk.vel_y; pos_sel = wrk.pos_y; end
      default: begin vel_sel = wrk.vel_z; pos_sel = wrk.pos_z; end
    endcase
  end

  // floor to q16.16 is the arithmetic shift, then saturate
  assign sum = {{10{pos_sel[31]}}, pos_sel} + {prod[56], prod[56:16]};
  always_comb begin
    if (!sum[41] && (sum[40:31] != '0)) begin
      pos_new = 32'sh7fffffff;
    end else if (sum[41] && (sum[40:31] != '1)) begin
      pos_new = 32'sh80000000;
    end else begin
      pos_new = sum[31:0];
    end
  end

  assign life_new     = wrk.life - $signed({1'b0, dt_q});
  assign life_new_pos = !life_new[24] && (life_new != '0);
  assign wrk_live     = !wrk.life[24] && (wrk.life != '0);
  assign div_num      = {life_new[23:0], 8'b0} - {8'b0, life_new[23:0]};
  assign div_start    = (state == S_AD_LIFE) && (wrk.full != '0) && life_new_pos;

  pps_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (wrk.full),
    .done  (div_done),
    .quo   (div_quo)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          unique case (cmd_t'(cmd))
            CMD_EMIT: state_next = S_EM_SCAN;
            CMD_ADV:  state_next = S_AD_SCAN;
            CMD_READ: state_next = S_RO_SCAN;
            default:  state_next = S_IDLE;
          endcase
        end
      end
      S_EM_SCAN: if (!live[idx] || idx_last) state_next = S_IDLE;
      S_AD_SCAN: begin
        if (live[idx]) state_next = S_AD_RD;
        else if (idx_last) state_next = S_IDLE;
      end
      S_AD_RD:   state_next = S_AD_MUL;
      S_AD_MUL:  state_next = S_AD_ADD;
      S_AD_ADD:  state_next = (ax == 2'd2) ? S_AD_LIFE : S_AD_MUL;
      S_AD_LIFE: state_next = div_start ? S_AD_DIV : S_AD_WR;
      S_AD_DIV:  if (div_done) state_next = S_AD_WR;
      S_AD_WR:   state_next = idx_last ? S_IDLE : S_AD_SCAN;
      S_RO_SCAN: begin
        if (live[idx]) state_next = S_RO_CAP;
        else if (idx_last) state_next = S_RO_END;
      end
      S_RO_CAP:  state_next = idx_last ? S_RO_END : S_RO_SCAN;
      S_RO_END:  state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    busy      = (state != S_IDLE);
    mem_we    = 1'b0;
    mem_wdata = wrk;
    unique case (state)
      S_EM_SCAN: begin
        mem_we    = !live[idx];
        mem_wdata = in_rec;
      end
      S_AD_WR: mem_we = 1'b1;
      default: mem_we = 1'b0;
    endcase
  end

  // slot memory
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[idx] <= mem_wdata;
    end
    rec_q <= mem[idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      live       <= '0;
      tally      <= '0;
      out_strobe <= 1'b0;
      pend_v     <= 1'b0;
    end else begin
      state      <= state_next;
      out_strobe <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            idx           <= '0;
            cnt           <= '0;
            dt_q          <= dt;
            in_rec.pos_x  <= pos_x;
            in_rec.pos_y  <= pos_y;
            in_rec.pos_z  <= pos_z;
            in_rec.vel_x  <= vel_x;
            in_rec.vel_y  <= vel_y;
            in_rec.vel_z  <= vel_z;
            in_rec.color  <= color_rgba;
            in_rec.psize  <= point_size;
            in_rec.life   <= $signed({1'b0, lifetime});
            in_rec.full   <= lifetime;
          end
        end
        S_EM_SCAN: begin
          if (!live[idx]) begin
            live[idx] <= (in_rec.full != '0);
          end else if (!idx_last) begin
            idx <= idx + SLOT_W'(1);
          end
        end
        S_AD_SCAN: begin
          if (!live[idx]) begin
            if (idx_last) tally <= cnt;
            else idx <= idx + SLOT_W'(1);
          end
        end
        S_AD_RD: begin
          wrk <= rec_q;
          ax  <= 2'd0;
        end
        S_AD_MUL: prod <= vel_sel * $signed({1'b0, dt_q});
        S_AD_ADD: begin
          unique case (ax)
            2'd0:    wrk.pos_x <= pos_new;
            2'd1:    wrk.pos_y <= pos_new;
            default: wrk.pos_z <= pos_new;
          endcase
          ax <= ax + 2'd1;
        end
        S_AD_LIFE: begin
          wrk.life <= life_new;
          if ((wrk.full != '0) && !life_new_pos) begin
            wrk.color[7:0] <= 8'd0;
          end
        end
        S_AD_DIV: if (div_done) wrk.color[7:0] <= div_quo;
        S_AD_WR: begin
          live[idx] <= wrk_live;
          cnt       <= cnt + CNT_W'(wrk_live);
          if (idx_last) tally <= cnt + CNT_W'(wrk_live);
          else idx <= idx + SLOT_W'(1);
        end
        S_RO_SCAN: begin
          if (!live[idx] && !idx_last) idx <= idx + SLOT_W'(1);
        end
        S_RO_CAP: begin
          if (pend_v) begin
            out_strobe     <= 1'b1;
            out_pos_x      <= pend.pos_x;
            out_pos_y      <= pend.pos_y;
            out_pos_z      <= pend.pos_z;
            out_color_rgba <= pend.color;
            out_point_size <= pend.psize;
            live_count     <= 7'(tally);
            last           <= 1'b0;
          end
          pend   <= rec_q;
          pend_v <= 1'b1;
          if (!idx_last) idx <= idx + SLOT_W'(1);
        end
        S_RO_END: begin
          if (pend_v) begin
            out_strobe     <= 1'b1;
            out_pos_x      <= pend.pos_x;
            out_pos_y      <= pend.pos_y;
            out_pos_z      <= pend.pos_z;
            out_color_rgba <= pend.color;
            out_point_size <= pend.psize;
            live_count     <= 7'(tally);
            last           <= 1'b1;
          end
          pend_v <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  `PPS_ASSERT_RUN(a_strobe_from_read, out_strobe |-> $past(state == S_RO_CAP || state == S_RO_END), "result strobe outside a read")
  `PPS_ASSERT_RUN(a_take_goes_busy, (accept && cmd != CMD_NOP) |=> busy, "accepted item did not start")
  `PPS_ASSERT_RUN(a_tally_range, tally <= CNT_W'(SLOTS), "live tally beyond pool size")
  `PPS_ASSERT_RUN(a_pend_clear_idle, (state == S_IDLE) |-> !pend_v, "pending result left after read")

endmodule

`default_nettype wire

### dv/particle_pool_step_tb.sv
// ----------------------------------------------------------------------------
// particle_pool_step_tb
// self-checking bench for the particle pool: emits, advances and readouts are
// driven with random gaps, a local model of the pool predicts every readout
// result and a monitor compares each strobed result field by field
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module particle_pool_step_tb;
  import pps_pkg::*;

  logic               clk;
  logic               rst;
  logic               start;
  logic               busy;
  logic [1:0]         cmd;
  logic signed [31:0] pos_x, pos_y, pos_z;
  logic signed [31:0] vel_x, vel_y, vel_z;
  logic [31:0]        color_rgba;
  logic [15:0]        point_size;
  logic [23:0]        lifetime;
  logic [23:0]        dt;
  logic               out_strobe;
  logic signed [31:0] out_pos_x, out_pos_y, out_pos_z;
  logic [31:0]        out_color_rgba;
  logic [15:0]        out_point_size;
  logic [6:0]         live_count;
  logic               last;

  typedef struct packed {
    logic [31:0] px;
    logic [31:0] py;
    logic [31:0] pz;
    logic [31:0] color;
    logic [15:0] psize;
    logic [6:0]  count;
    logic        last;
  } particle_out_t;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] px, py, pz, vx, vy, vz;
    logic [31:0] color;
    logic [15:0] psize;
    logic [23:0] life;
    logic [23:0] dt;
  } pool_item_t;

  longint         m_px[SLOTS], m_py[SLOTS], m_pz[SLOTS];
  longint         m_vx[SLOTS], m_vy[SLOTS], m_vz[SLOTS];
  logic [31:0]    m_color[SLOTS];
  logic [15:0]    m_psize[SLOTS];
  longint         m_life[SLOTS];
  longint         m_full[SLOTS];
  int             m_tally;
  particle_out_t  readout_q[$];
  int             errors;
  bit             idle_en;

  particle_pool_step DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd),
    .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
    .vel_x(vel_x), .vel_y(vel_y), .vel_z(vel_z),
    .color_rgba(color_rgba), .point_size(point_size),
    .lifetime(lifetime), .dt(dt), .out_strobe(out_strobe),
    .out_pos_x(out_pos_x), .out_pos_y(out_pos_y), .out_pos_z(out_pos_z),
    .out_color_rgba(out_color_rgba), .out_point_size(out_point_size),
    .live_count(live_count), .last(last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #400ms;
    $display("== FAIL ==");
    $finish;
  end

  function automatic longint floor_q16(longint p);
    if (p >= 0) return p / 65536;
    return -((-p + 65535) / 65536);
  endfunction

  function automatic longint move_axis(longint p, longint v, longint step);
    longint s;
    s = p + floor_q16(v * step);
    if (s > 64'sd2147483647) s = 64'sd2147483647;
    if (s < -64'sd2147483648) s = -64'sd2147483648;
    return s;
  endfunction

  task automatic pool_reset_model();
    for (int i = 0; i < SLOTS; i++) begin
      m_px[i] = 0; m_py[i] = 0; m_pz[i] = 0;
      m_vx[i] = 0; m_vy[i] = 0; m_vz[i] = 0;
      m_color[i] = '0; m_psize[i] = '0;
      m_life[i] = -65536; m_full[i] = 0;
    end
    m_tally = 0;
  endtask

  task automatic predict_pool(input pool_item_t it);
    int n;
    longint a;
    particle_out_t r;
    n = 0;
    case (cmd_t'(it.cmd))
      CMD_EMIT: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (m_life[i] <= 0) begin
            m_px[i] = longint'(signed'(it.px));
            m_py[i] = longint'(signed'(it.py));
            m_pz[i] = longint'(signed'(it.pz));
            m_vx[i] = longint'(signed'(it.vx));
            m_vy[i] = longint'(signed'(it.vy));
            m_vz[i] = longint'(signed'(it.vz));
            m_color[i] = it.color;
            m_psize[i] = it.psize;
            m_life[i] = longint'(it.life);
            m_full[i] = longint'(it.life);
            break;
          end
        end
      end
      CMD_ADV: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (m_life[i] > 0) begin
            m_px[i] = move_axis(m_px[i], m_vx[i], longint'(it.dt));
            m_py[i] = move_axis(m_py[i], m_vy[i], longint'(it.dt));
            m_pz[i] = move_axis(m_pz[i], m_vz[i], longint'(it.dt));
            m_life[i] -= longint'(it.dt);
            if (m_full[i] > 0) begin
              a = 0;
              if (m_life[i] > 0) a = (255 * m_life[i]) / m_full[i];
              if (a > 255) a = 255;
              m_color[i][7:0] = a[7:0];
            end
            if (m_life[i] > 0) n++;
          end
        end
        m_tally = n;
      end
      CMD_READ: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (m_life[i] > 0) begin
            r.px = m_px[i][31:0]; r.py = m_py[i][31:0]; r.pz = m_pz[i][31:0];
            r.color = m_color[i]; r.psize = m_psize[i];
            r.count = m_tally[6:0]; r.last = 1'b0;
            readout_q = {readout_q, r};
            n++;
          end
        end
        if (n > 0) readout_q[$].last = 1'b1;
      end
      default: ;
    endcase
  endtask

  task automatic send_item(input pool_item_t it);
    @(negedge clk);
    while (idle_en && $urandom_range(99) < 32) @(negedge clk);
    start <= 1'b1;
    cmd <= it.cmd;
    pos_x <= it.px; pos_y <= it.py; pos_z <= it.pz;
    vel_x <= it.vx; vel_y <= it.vy; vel_z <= it.vz;
    color_rgba <= it.color; point_size <= it.psize;
    lifetime <= it.life; dt <= it.dt;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_pool(it);
    @(negedge clk);
    start <= 1'b0;
  endtask

  function automatic pool_item_t rand_item(input logic [1:0] c);
    pool_item_t it;
    it.cmd = c;
    it.px = $urandom; it.py = $urandom; it.pz = $urandom;
    it.vx = $urandom; it.vy = $urandom; it.vz = $urandom;
    if ($urandom_range(3) != 0) begin
      it.px = $signed(it.px) >>> 8; it.vx = $signed(it.vx) >>> 10;
      it.vy = $signed(it.vy) >>> 10; it.vz = $signed(it.vz) >>> 10;
    end
    it.color = $urandom;
    it.psize = 16'($urandom);
    it.life = 24'(($urandom_range(7) == 0) ? $urandom : $urandom_range(600000));
    if ($urandom_range(15) == 0) it.life = '0;
    it.dt = 24'(($urandom_range(7) == 0) ? $urandom : $urandom_range(40000));
    if ($urandom_range(15) == 0) it.dt = '0;
    return it;
  endfunction

  task automatic wait_drained();
    while (readout_q.size() != 0) @(negedge clk);
  endtask

  always @(posedge clk) begin
    particle_out_t e;
    if (!rst && out_strobe) begin
      if (readout_q.size() == 0) begin
        $error("unexpected result, pos_x %h", out_pos_x);
        errors++;
      end else begin
        e = readout_q.pop_front();
        if (out_pos_x !== e.px) begin
          $error("pos_x exp %h got %h", e.px, out_pos_x); errors++;
        end
        if (out_pos_y !== e.py) begin
          $error("pos_y exp %h got %h", e.py, out_pos_y); errors++;
        end
        if (out_pos_z !== e.pz) begin
          $error("pos_z exp %h got %h", e.pz, out_pos_z); errors++;
        end
        if (out_color_rgba !== e.color) begin
          $error("color_rgba exp %h got %h", e.color, out_color_rgba); errors++;
        end
        if (out_point_size !== e.psize) begin
          $error("point_size exp %h got %h", e.psize, out_point_size); errors++;
        end
        if (live_count !== e.count) begin
          $error("live_count exp %0d got %0d", e.count, live_count); errors++;
        end
        if (last !== e.last) begin
          $error("last exp %b got %b", e.last, last); errors++;
        end
      end
    end
  end

  task automatic test_directed();
    pool_item_t it;
    // empty readout and unused command
    send_item(rand_item(CMD_READ));
    send_item(rand_item(CMD_NOP));
    it = rand_item(CMD_EMIT);
    it.px = 32'h7fff_ffff; it.vx = 32'h7fff_ffff;
    it.py = 32'h8000_0000; it.vy = 32'h8000_0000;
    it.pz = '0; it.vz = 32'hffff_ffff;
    it.color = '1; it.psize = '1; it.life = 24'hff_ffff;
    send_item(it);
    it.color = '0; it.psize = '0; it.life = 24'd1;
    it.px = 32'h8000_0000; it.vx = '0;
    send_item(it);
    it.life = '0;
    send_item(it);
    send_item(rand_item(CMD_READ));
    it = rand_item(CMD_ADV); it.dt = '0;
    send_item(it);
    send_item(rand_item(CMD_READ));
    it.dt = 24'd65536;
    send_item(it);
    send_item(rand_item(CMD_READ));
    it.dt = 24'hff_ffff;
    send_item(it);
    send_item(rand_item(CMD_READ));
    wait_drained();
  endtask

  task automatic test_pool_full();
    pool_item_t it;
    for (int i = 0; i < SLOTS + 3; i++) begin
      it = rand_item(CMD_EMIT);
      it.life = 24'(200000 + i);
      send_item(it);
    end
    it = rand_item(CMD_ADV); it.dt = 24'd1000;
    send_item(it);
    send_item(rand_item(CMD_READ));
    wait_drained();
    it.dt = 24'hff_ffff;
    send_item(it);
    send_item(rand_item(CMD_READ));
  endtask

  task automatic test_random(input int count);
    int r;
    logic [1:0] c;
    for (int k = 0; k < count; k++) begin
      idle_en = !(k >= count / 3 && k < count / 2);
      r = $urandom_range(99);
      c = (r < 50) ? CMD_EMIT : (r < 75) ? CMD_ADV : (r < 97) ? CMD_READ : CMD_NOP;
      send_item(rand_item(c));
      if (k == count / 4) wait_drained();
    end
  endtask

  initial begin
    errors = 0;
    idle_en = 1'b1;
    rst = 1'b1; start = 1'b0; cmd = CMD_NOP;
    pos_x = '0; pos_y = '0; pos_z = '0; vel_x = '0; vel_y = '0; vel_z = '0;
    color_rgba = '0; point_size = '0; lifetime = '0; dt = '0;
    pool_reset_model();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_directed();
    test_pool_full();
    test_random(384);
    wait_drained();
    repeat (400) @(posedge clk);
    if (errors == 0 && readout_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
